// ===== design/type_length_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// type_length_frame_parser_macros
// assertion macros used by the frame parser checker
// ----------------------------------------------------------------------------
`ifndef TYPE_LENGTH_FRAME_PARSER_MACROS_SVH
`define TYPE_LENGTH_FRAME_PARSER_MACROS_SVH

// property checked out of reset
`define TLFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked also while reset is held
`define TLFP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/tlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfp_pkg
// types and constants of the type-length frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package tlfp_pkg;

  localparam int unsigned HdrTypeBytes  = 4;
  localparam int unsigned HdrTotalBytes = 8;
  localparam logic [31:0] ResetMaxLen   = 32'd4095;

  typedef enum logic [1:0] {
    EV_PAYLOAD  = 2'd0,
    EV_EMPTY    = 2'd1,
    EV_TOO_LONG = 2'd2
  } tlfp_event_e;

  typedef struct packed {
    logic       new_connection;
    logic [7:0] data_byte;
  } tlfp_item_t;

  typedef struct packed {
    tlfp_event_e event_kind;
    logic [31:0] frame_type;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic [31:0] byte_index;
    logic        last_byte;
  } tlfp_result_t;

  // handshake between input register and parser core
  typedef struct packed {
    logic valid;
    logic fire;
  } tlfp_in_ctl_t;

endpackage

`default_nettype wire

// ===== design/tlfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// tlfp_in_reg
// input register stage, holds one received beat until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tlfp_in_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire tlfp_pkg::tlfp_item_t s_item_i,
  input  wire logic                take_i,
  output tlfp_pkg::tlfp_item_t     item_o,
  output logic                     valid_o
);

  logic                 valid_q, valid_d;
  tlfp_pkg::tlfp_item_t item_q;

  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== design/tlfp_core.sv =====
// ----------------------------------------------------------------------------
// tlfp_core
// parser state and single-pass header/payload decode of one byte
// ----------------------------------------------------------------------------
`default_nettype none

module tlfp_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire tlfp_pkg::tlfp_in_ctl_t in_ctl_i,
  input  wire tlfp_pkg::tlfp_item_t in_item_i,
  output logic                      res_valid_o,
  output tlfp_pkg::tlfp_result_t    res_o
);

  localparam logic [3:0] HdrType  = 4'(tlfp_pkg::HdrTypeBytes);
  localparam logic [3:0] HdrTotal = 4'(tlfp_pkg::HdrTotalBytes);

  logic [31:0] max_len_q;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] type_q, type_d;
  logic [31:0] len_q, len_d;
  logic [31:0] pay_pos_q, pay_pos_d;

  logic [3:0]  hp;
  logic [31:0] tw, lw, pp;
  logic [7:0]  b;
  logic        last;
  logic [1:0]  lane;

  always_comb begin
    b    = in_item_i.data_byte;
    hp   = in_item_i.new_connection ? 4'd0  : hdr_pos_q;
    tw   = in_item_i.new_connection ? 32'd0 : type_q;
    lw   = in_item_i.new_connection ? 32'd0 : len_q;
    pp   = in_item_i.new_connection ? 32'd0 : pay_pos_q;
    lane = hp[1:0];
    last = ({1'b0, pp} + 33'd1) >= {1'b0, lw};

    hdr_pos_d   = hp;
    type_d      = tw;
    len_d       = lw;
    pay_pos_d   = pp;
    res_valid_o = 1'b0;

    if (hp < HdrType) begin
      unique case (lane)
        2'd0: type_d[7:0]   = b;
        2'd1: type_d[15:8]  = b;
        2'd2: type_d[23:16] = b;
        2'd3: type_d[31:24] = b;
        default: type_d = tw;
      endcase
      hdr_pos_d = hp + 4'd1;
    end else if (hp < HdrTotal) begin
      unique case (lane)
        2'd0: len_d[7:0]   = b;
        2'd1: len_d[15:8]  = b;
        2'd2: len_d[23:16] = b;
        2'd3: len_d[31:24] = b;
        default: len_d = lw;
      endcase
      hdr_pos_d = hp + 4'd1;
      if (hdr_pos_d == HdrTotal) begin
        pay_pos_d = 32'd0;
        if (len_d == 32'd0 || len_d > max_len_q) begin
          hdr_pos_d   = 4'd0;
          res_valid_o = 1'b1;
        end
      end
    end else begin
      res_valid_o = 1'b1;
      if (last) begin
        hdr_pos_d = 4'd0;
        pay_pos_d = 32'd0;
      end else begin
        hdr_pos_d = HdrTotal;
        pay_pos_d = pp + 32'd1;
      end
    end

    res_o.frame_type   = type_d;
    res_o.frame_length = len_d;
    if (hp >= HdrTotal) begin
      res_o.event_kind   = tlfp_pkg::EV_PAYLOAD;
      res_o.payload_byte = b;
      res_o.byte_index   = pp;
      res_o.last_byte    = last;
    end else begin
      res_o.event_kind   = (len_d == 32'd0) ? tlfp_pkg::EV_EMPTY : tlfp_pkg::EV_TOO_LONG;
      res_o.payload_byte = 8'd0;
      res_o.byte_index   = 32'd0;
      res_o.last_byte    = (len_d == 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= tlfp_pkg::ResetMaxLen;
      hdr_pos_q <= 4'd0;
      type_q    <= 32'd0;
      len_q     <= 32'd0;
      pay_pos_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (in_ctl_i.fire) begin
        hdr_pos_q <= hdr_pos_d;
        type_q    <= type_d;
        len_q     <= len_d;
        pay_pos_q <= pay_pos_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tlfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tlfp_out_reg
// result register, holds one event beat until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tlfp_out_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic                   res_valid_i,
  input  wire tlfp_pkg::tlfp_result_t res_i,
  output logic                        free_o,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output tlfp_pkg::tlfp_result_t      m_res_o
);

  logic                   valid_q, valid_d;
  tlfp_pkg::tlfp_result_t res_q;

  assign free_o  = !valid_q || m_ready_i;
  assign valid_d = free_o ? (load_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

// ===== design/type_length_frame_parser.sv =====
// ----------------------------------------------------------------------------
// type_length_frame_parser
// Cuts a byte stream into frames of a 4-byte type word, a 4-byte length word
// (both little-endian) and that many payload bytes. Each payload byte leaves as
// one event beat with type, length, index and tlast; a zero length gives an
// empty-frame event, a length above max_payload_len a too-long event, after
// which a new header is read. tuser on the input clears the parser before the
// byte. The block takes one byte per cycle unless output backpressure holds
// it; a byte's event reaches the output through the input register and then
// the result register: the input register holds the byte while the parse
// logic updates the frame state and loads the result register once it is
// free. Header bytes that give no event pass the input register the same way.
// Backpressure on the output holds the input once both registers are full.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module type_length_frame_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i,     // max_payload_len
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]   s_axis_tuser,   // [0] new_connection
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // [31:0] frame_type, [63:32] frame_length,
                                            // [71:64] payload_byte, [103:72] byte_index
  output logic [1:0]        m_axis_tuser,   // [1:0] event_kind
  output logic              m_axis_tlast    // last_byte
);

  tlfp_pkg::tlfp_item_t   s_item;
  tlfp_pkg::tlfp_item_t   in_item;
  tlfp_pkg::tlfp_in_ctl_t in_ctl;
  tlfp_pkg::tlfp_result_t res;
  tlfp_pkg::tlfp_result_t m_res;
  logic                   in_valid;
  logic                   out_free;
  logic                   res_valid;

  assign cfg_ready_o = 1'b1;

  assign s_item.data_byte      = s_axis_tdata;
  assign s_item.new_connection = s_axis_tuser[0];

  assign in_ctl.valid = in_valid;
  assign in_ctl.fire  = in_valid && out_free;

  tlfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (in_ctl.fire),
    .item_o    (in_item),
    .valid_o   (in_valid)
  );

  tlfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_ctl_i    (in_ctl),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tlfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_ctl.valid),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata = {m_res.byte_index, m_res.payload_byte,
                         m_res.frame_length, m_res.frame_type};
  assign m_axis_tuser = m_res.event_kind;
  assign m_axis_tlast = m_res.last_byte;

endmodule

`default_nettype wire

// ===== design/tlfp_checker.sv =====
// ----------------------------------------------------------------------------
// tlfp_checker
// port-level checks of the frame parser event stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "type_length_frame_parser_macros.svh"

module tlfp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  logic [31:0]  len;
  logic [7:0]   pbyte;
  logic [31:0]  idx;
  logic [106:0] beat;
  logic         stall;
  logic         empty_ev;
  logic         long_ev;
  logic         pay_ev;
  logic         zero_len;
  logic         no_payload;
  logic         last_ok;

  assign len   = m_axis_tdata[63:32];
  assign pbyte = m_axis_tdata[71:64];
  assign idx   = m_axis_tdata[103:72];

  // whole beat as seen on the output
  assign beat  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign stall = m_axis_tvalid && !m_axis_tready;

  assign empty_ev = m_axis_tvalid && (m_axis_tuser == tlfp_pkg::EV_EMPTY);
  assign long_ev  = m_axis_tvalid && (m_axis_tuser == tlfp_pkg::EV_TOO_LONG);
  assign pay_ev   = m_axis_tvalid && (m_axis_tuser == tlfp_pkg::EV_PAYLOAD);

  assign zero_len   = (len == 32'd0);
  assign no_payload = (pbyte == 8'd0) && (idx == 32'd0);
  assign last_ok    = m_axis_tlast == (({1'b0, idx} + 33'd1) == {1'b0, len});

  `TLFP_ASSERT_RST(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid, "tvalid during reset")

  `TLFP_ASSERT(a_hold_stalled, stall |=> m_axis_tvalid && $stable(beat), "stalled beat changed")

  `TLFP_ASSERT(a_empty_frame, empty_ev |-> m_axis_tlast && zero_len && no_payload, "bad empty event")

  `TLFP_ASSERT(a_too_long, long_ev |-> !m_axis_tlast && !zero_len && no_payload, "bad too-long event")

  `TLFP_ASSERT(a_payload_index, pay_ev |-> idx < len && last_ok, "payload index or last mark wrong")

endmodule

bind type_length_frame_parser tlfp_checker u_tlfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/type_length_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// type_length_frame_parser_test
// Self-checking bench for the type-length frame parser. Byte beats are built
// from whole frames (empty, too long, normal, boundary lengths) mixed with cut
// frames, new-connection restarts and raw noise, under several length limits.
// A scoreboard predicts every event beat and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module type_length_frame_parser_test;
  import tlfp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 4;

  class frame_scoreboard;
    tlfp_result_t expected_q[$];
    logic [31:0]  max_len;
    int           hdr_pos;
    logic [31:0]  type_w;
    logic [31:0]  len_w;
    logic [31:0]  pay_pos;
    int           errors;
    int           beats_in;
    int           events_seen;
    int           kind_count[3];

    function new();
      max_len = ResetMaxLen;
      clear_frame();
      errors = 0;
      beats_in = 0;
      events_seen = 0;
      kind_count = '{0, 0, 0};
    endfunction

    function void clear_frame();
      hdr_pos = 0;
      type_w  = '0;
      len_w   = '0;
      pay_pos = '0;
    endfunction

    function void set_max_len(logic [31:0] value);
      max_len = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_event(tlfp_event_e kind, logic [7:0] pb, logic [31:0] idx, logic last);
      tlfp_result_t r;
      r.event_kind   = kind;
      r.frame_type   = type_w;
      r.frame_length = len_w;
      r.payload_byte = pb;
      r.byte_index   = idx;
      r.last_byte    = last;
      expected_q.push_back(r);
    endfunction

    function void note_beat(logic [7:0] b, logic restart);
      logic [31:0] idx;
      logic        last;
      beats_in++;
      if (restart) clear_frame();
      if (hdr_pos < HdrTypeBytes) begin
        type_w[8*hdr_pos +: 8] = b;
        hdr_pos++;
      end else if (hdr_pos < HdrTotalBytes) begin
        len_w[8*(hdr_pos - HdrTypeBytes) +: 8] = b;
        hdr_pos++;
        if (hdr_pos == HdrTotalBytes) begin
          pay_pos = '0;
          if (len_w == '0) begin
            hdr_pos = 0;
            push_event(EV_EMPTY, 8'h00, 32'h0, 1'b1);
          end else if (len_w > max_len) begin
            hdr_pos = 0;
            push_event(EV_TOO_LONG, 8'h00, 32'h0, 1'b0);
          end
        end
      end else begin
        idx  = pay_pos;
        last = ({1'b0, idx} + 33'd1) >= {1'b0, len_w};
        push_event(EV_PAYLOAD, b, idx, last);
        if (last) begin
          hdr_pos = 0;
          pay_pos = '0;
        end else begin
          hdr_pos = HdrTotalBytes;
          pay_pos = idx + 32'd1;
        end
      end
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
      $display("mismatch at event %0d: %s got 0x%0h expected 0x%0h",
               events_seen, what, got_v, exp_v);
      errors++;
    endtask

    task check_result(tlfp_result_t got);
      tlfp_result_t exp;
      events_seen++;
      if (expected_q.size() == 0) begin
        report("event beat with nothing pending, kind", 32'(got.event_kind), 32'h0);
      end else begin
        exp = expected_q.pop_front();
        kind_count[exp.event_kind]++;
        if (got.event_kind !== exp.event_kind)
          report("event_kind", 32'(got.event_kind), 32'(exp.event_kind));
        if (got.frame_type !== exp.frame_type)
          report("frame_type", got.frame_type, exp.frame_type);
        if (got.frame_length !== exp.frame_length)
          report("frame_length", got.frame_length, exp.frame_length);
        if (got.payload_byte !== exp.payload_byte)
          report("payload_byte", 32'(got.payload_byte), 32'(exp.payload_byte));
        if (got.byte_index !== exp.byte_index)
          report("byte_index", got.byte_index, exp.byte_index);
        if (got.last_byte !== exp.last_byte)
          report("last_byte", 32'(got.last_byte), 32'(exp.last_byte));
      end
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  frame_scoreboard sb = new();

  bit           no_stalls;
  bit           broken_prev;
  logic [31:0]  tb_max_len;
  int unsigned  sent_count;
  int unsigned  cycles;

  type_length_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // output stalls
  always @(negedge clk_i) begin
    m_axis_tready = no_stalls || ($urandom_range(0, 99) >= 21);
  end

  // beat monitor
  always @(posedge clk_i) begin
    tlfp_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_kind   = tlfp_event_e'(m_axis_tuser);
        got.frame_type   = m_axis_tdata[31:0];
        got.frame_length = m_axis_tdata[63:32];
        got.payload_byte = m_axis_tdata[71:64];
        got.byte_index   = m_axis_tdata[103:72];
        got.last_byte    = m_axis_tlast;
        sb.check_result(got);
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tdata, s_axis_tuser[0]);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (!no_stalls && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    @(negedge clk_i);
  endtask

  // header bytes, then random payload, cut after n_bytes beats
  task automatic send_frame(input logic [31:0] ftype, input logic [31:0] flen,
                            input int n_bytes, input bit restart);
    logic [7:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      if (i < 4) b = ftype[8*i +: 8];
      else if (i < 8) b = flen[8*(i-4) +: 8];
      else b = 8'($urandom);
      send_byte(b, (i == 0) ? restart : 1'b0);
    end
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] value);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_max_len(value);
    tb_max_len = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_frame();
    logic [31:0] flen;
    int          pick;
    int          full;
    int          total;
    bit          restart;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      flen = '0;
    end else if (pick < 30 && tb_max_len != 32'hFFFF_FFFF) begin
      flen = $urandom_range(0, 1) ? tb_max_len + 32'd1
                                  : $urandom_range(32'hFFFF_FFFF, tb_max_len + 32'd1);
    end else if (pick < 38 && tb_max_len <= 64 && tb_max_len != 0) begin
      flen = tb_max_len;
    end else if (pick < 42 && tb_max_len > 64) begin
      flen = 32'hFFFF_FFFF;
    end else if (tb_max_len == 0) begin
      flen = $urandom_range(1, 8);
    end else begin
      flen = $urandom_range(1, (tb_max_len < 40) ? tb_max_len : 40);
    end
    if (flen == 0 || flen > tb_max_len) full = 8;
    else if (flen > 64) full = 0;
    else full = 8 + int'(flen);
    // a huge accepted length is always cut short
    if (full == 0) total = 8 + $urandom_range(1, 12);
    else if ($urandom_range(0, 99) < 10) total = $urandom_range(1, full - 1);
    else total = full;
    restart = broken_prev || ($urandom_range(0, 99) < 8);
    send_frame(32'($urandom), flen, total, restart);
    broken_prev = (total != full);
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) send_byte(8'($urandom), 1'($urandom));
    broken_prev = 1'b1;
  endtask

  initial begin
    logic [31:0] limits [5];
    int unsigned goal;
    int          frames;
    limits        = '{ResetMaxLen, 32'h0, 32'hFFFF_FFFF, 32'd16, 32'd0};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    no_stalls     = 1'b0;
    broken_prev   = 1'b0;
    tb_max_len    = ResetMaxLen;
    sent_count    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: too long at the reset limit, cut frame, restart into empty frame, all-ones length
    send_frame(32'h0000_0000, ResetMaxLen + 32'd1, 8, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'd3, 10, 1'b0);
    send_frame(32'h0000_0000, 32'h0, 8, 1'b1);
    send_frame(32'hA5C3_0F96, 32'hFFFF_FFFF, 8, 1'b0);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_max_len((p == 4) ? $urandom_range(1, 64) : limits[p]);
      no_stalls = (p == 2);
      goal      = sent_count + 270;
      frames    = 0;
      while (sent_count < goal) begin
        if ($urandom_range(0, 99) < 5) noise_burst();
        else random_frame();
        frames++;
        if (frames % 40 == 0) drain();
      end
    end

    drain();
    repeat (SettleCycles * 2) @(posedge clk_i);
    $display("run covered %0d byte beats and %0d events: %0d payload, %0d empty, %0d too long",
             sb.beats_in, sb.events_seen, sb.kind_count[EV_PAYLOAD],
             sb.kind_count[EV_EMPTY], sb.kind_count[EV_TOO_LONG]);
    $display("length limits used: reset value, zero, all ones, 16 and one random small value");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $display("%0d expected events never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
